// File: hdl/isra_pkg.sv
// ----------------------------------------------------------------------------
// isra_pkg
// shared constants for the interval set range assign block
// ----------------------------------------------------------------------------
package isra_pkg;
  localparam int unsigned MaxRangesDef = 64;
  localparam int unsigned PosBitsDef   = 32;
  localparam int unsigned FieldBits    = 32;

  typedef enum logic [0:0] {
    FuncMark  = 1'b0,
    FuncClear = 1'b1
  } func_e;
endpackage

// File: hdl/isra_ram.sv
// ----------------------------------------------------------------------------
// isra_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module isra_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hdl/interval_set_range_assign_top.sv
// ----------------------------------------------------------------------------
// interval_set_range_assign_top
// sorted table of disjoint marked ranges with running marked total
// ----------------------------------------------------------------------------
// One request at a time. The table lives in two ping-pong banks: the
// request streams the live bank (one entry per cycle through the read port,
// held back while a split or inserted entry waits to be written) into the
// spare bank, then the spare bank becomes live. A request that is empty
// after clipping skips the scan. The next request is not taken while a
// result waits to be accepted. The single read and single write port of
// each bank set the pace. Writing domain_size reloads the table and is held
// off while a request or a result is in flight. Right after reset entry 0
// is loaded, and both channels are held off.
module interval_set_range_assign_top
  import isra_pkg::*;
#(
  parameter int unsigned MaxRanges = MaxRangesDef,
  parameter int unsigned PosBits   = PosBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [FieldBits-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [FieldBits-1:0] range_low_i,
  input  logic [FieldBits-1:0] range_high_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FieldBits-1:0] marked_total_o,
  output logic                 table_overflow_o
);
  localparam int unsigned AW = $clog2(MaxRanges);
  localparam int unsigned CW = $clog2(MaxRanges + 2);
  localparam int unsigned PW = PosBits;
  localparam int unsigned EW = 2 * PW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned XW = FieldBits + PW;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRead = 5'b00010,
    StScan = 5'b00100,
    StTail = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic          bank_q, bank_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] total_q, total_d;
  logic [PW-1:0] top_q;
  logic          func_q;
  logic [PW-1:0] lo_q, hi_q;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] n_q, n_d;
  logic [SW-1:0] sum_q, sum_d;
  logic          placed_q, placed_d;
  logic [PW-1:0] ms_q, ms_d, me_q, me_d;
  logic          ok_q, ok_d;
  logic          pend_q, pend_d;
  logic [EW-1:0] pend_w_q, pend_w_d;
  logic          ov_q;
  logic          oval_q;
  logic          boot_q;

  // ram ports
  logic          we  [2];
  logic [AW-1:0] wa  [2];
  logic [EW-1:0] wd  [2];
  logic [AW-1:0] ra;
  logic [EW-1:0] rdat [2];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    isra_ram #(.Width(EW), .Depth(MaxRanges)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[b]),
      .waddr_i(wa[b]),
      .wdata_i(wd[b]),
      .raddr_i(ra),
      .rdata_o(rdat[b])
    );
  end

  logic in_acc, out_acc, cfg_acc;
  assign in_stall_o  = boot_q || (state_q != StIdle) || oval_q || cfg_valid_i;
  assign cfg_ready_o = !boot_q && (state_q == StIdle) && !oval_q;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign out_valid_o      = oval_q;
  assign marked_total_o   = FieldBits'(total_q);
  assign table_overflow_o = ov_q;

  // clipped request
  logic [PW-1:0] rlo, rhi, clo, chi, cfg_top;
  logic [XW-1:0] cfg_x;
  assign rlo = PW'(range_low_i);
  assign rhi = PW'(range_high_i);
  assign clo = (rlo == '0) ? PW'(1) : rlo;
  assign chi = (rhi > top_q) ? top_q : rhi;
  assign cfg_x = {{PW{1'b0}}, cfg_data_i};
  assign cfg_top = (cfg_x > XW'({PW{1'b1}})) ? {PW{1'b1}} : cfg_x[PW-1:0];

  // current entry
  logic [PW-1:0] es, ee;
  assign es = rdat[bank_q][EW-1:PW];
  assign ee = rdat[bank_q][PW-1:0];
  logic [SW-1:0] es_x, ee_x, lo_x, hi_x;
  assign es_x = {1'b0, es};
  assign ee_x = {1'b0, ee};
  assign lo_x = {1'b0, lo_q};
  assign hi_x = {1'b0, hi_q};

  // emit helper: up to one write per cycle into the spare bank
  logic          em_v;
  logic [PW-1:0] em_s, em_e;
  logic          full;
  assign full = (n_q >= CW'(MaxRanges));

  always_comb begin
    state_d  = state_q;
    bank_d   = bank_q;
    cnt_d    = cnt_q;
    total_d  = total_q;
    rd_d     = rd_q;
    n_d      = n_q;
    sum_d    = sum_q;
    placed_d = placed_q;
    ms_d     = ms_q;
    me_d     = me_q;
    ok_d     = ok_q;
    pend_d   = pend_q;
    pend_w_d = pend_w_q;
    em_v     = 1'b0;
    em_s     = '0;
    em_e     = '0;
    ra       = rd_q[AW-1:0];
    case (state_q)
      StIdle: begin
        if (cfg_acc) begin
          bank_d  = 1'b0;
          cnt_d   = (cfg_top == '0) ? '0 : CW'(1);
          total_d = cfg_top;
        end else if (in_acc) begin
          rd_d     = '0;
          n_d      = '0;
          sum_d    = '0;
          placed_d = 1'b0;
          ms_d     = clo;
          me_d     = chi;
          ok_d     = 1'b1;
          pend_d   = 1'b0;
          ra       = '0;
          state_d  = (chi >= clo) ? StRead : StDone;
          ok_d     = (chi >= clo);
          if (chi >= clo) rd_d = CW'(1);
        end
      end
      StRead: begin
        // first read issued; data of entry 0 arrives next cycle
        ra      = '0;
        state_d = (cnt_q == '0) ? StTail : StScan;
      end
      StScan: begin
        if (pend_q) begin
          em_v   = 1'b1;
          em_s   = pend_w_q[EW-1:PW];
          em_e   = pend_w_q[PW-1:0];
          pend_d = 1'b0;
          // the read address set here is replaced below by entry rd_q
          ra     = AW'(rd_q - CW'(1));
        end else begin
          if (func_q == FuncMark) begin
            if (ee_x + SW'(1) < lo_x) begin
              em_v = 1'b1; em_s = es; em_e = ee;
            end else if (es_x > hi_x + SW'(1)) begin
              if (!placed_q) begin
                em_v = 1'b1; em_s = ms_q; em_e = me_q;
                placed_d = 1'b1;
                pend_d = 1'b1; pend_w_d = {es, ee};
              end else begin
                em_v = 1'b1; em_s = es; em_e = ee;
              end
            end else begin
              if (es < ms_q) ms_d = es;
              if (ee > me_q) me_d = ee;
            end
          end else begin
            if (ee < lo_q || es > hi_q) begin
              em_v = 1'b1; em_s = es; em_e = ee;
            end else if (es < lo_q) begin
              em_v = 1'b1; em_s = es; em_e = lo_q - PW'(1);
              if (ee > hi_q) begin
                pend_d = 1'b1; pend_w_d = {hi_q + PW'(1), ee};
              end
            end else if (ee > hi_q) begin
              em_v = 1'b1; em_s = hi_q + PW'(1); em_e = ee;
            end
          end
        end
        if (!pend_d && !pend_q) begin
          ra = rd_q[AW-1:0];
          if (rd_q == cnt_q) state_d = StTail;
          else rd_d = rd_q + CW'(1);
        end else if (pend_d) begin
          ra = AW'(rd_q - CW'(1));
        end else begin
          ra = rd_q[AW-1:0];
          if (rd_q == cnt_q) state_d = StTail;
          else rd_d = rd_q + CW'(1);
        end
        if (pend_q) begin
          ra = rd_q[AW-1:0];
        end
      end
      StTail: begin
        if (func_q == FuncMark && !placed_q) begin
          em_v = 1'b1; em_s = ms_q; em_e = me_q;
          placed_d = 1'b1;
        end
        state_d = StDone;
      end
      StDone: begin
        state_d = StIdle;
        if (ok_q) begin
          bank_d  = !bank_q;
          cnt_d   = n_q;
          total_d = PW'(sum_q);
        end
      end
      default: state_d = StIdle;
    endcase
    if (em_v) begin
      if (full) ok_d = 1'b0;
      else begin
        n_d   = n_q + CW'(1);
        sum_d = sum_q + ({1'b0, em_e} - {1'b0, em_s} + SW'(1));
      end
    end
  end

  // when an emit is pending, entry rd_q-1 has already been consumed; the
  // next scan cycle must see entry rd_q, so the read above targets it
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      we[b] = 1'b0;
      wa[b] = '0;
      wd[b] = '0;
    end
    if (boot_q) begin
      // reset image of entry 0 of bank 0
      we[0] = 1'b1;
      wd[0] = {PW'(1), PW'(1)};
    end else if (state_q == StIdle && cfg_acc) begin
      we[0] = 1'b1;
      wd[0] = {PW'(1), cfg_top};
    end else if (em_v && !full) begin
      we[!bank_q] = 1'b1;
      wa[!bank_q] = n_q[AW-1:0];
      wd[!bank_q] = {em_s, em_e};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      bank_q   <= 1'b0;
      cnt_q    <= CW'(1);
      total_q  <= PW'(1);
      top_q    <= PW'(1);
      oval_q   <= 1'b0;
      ov_q     <= 1'b0;
      rd_q     <= '0;
      n_q      <= '0;
      sum_q    <= '0;
      placed_q <= 1'b0;
      ok_q     <= 1'b0;
      pend_q   <= 1'b0;
      boot_q   <= 1'b1;
    end else begin
      state_q  <= state_d;
      bank_q   <= bank_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
      rd_q     <= rd_d;
      n_q      <= n_d;
      sum_q    <= sum_d;
      placed_q <= placed_d;
      ok_q     <= ok_d;
      pend_q   <= pend_d;
      boot_q   <= 1'b0;
      if (cfg_acc) top_q <= cfg_top;
      if (state_q == StDone) begin
        oval_q <= 1'b1;
        ov_q   <= (hi_q >= lo_q) && !ok_q;
      end else if (out_acc) begin
        oval_q <= 1'b0;
      end
    end
  end

  // request fields and scan scratch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      lo_q   <= clo;
      hi_q   <= chi;
    end
    ms_q     <= ms_d;
    me_q     <= me_d;
    pend_w_q <= pend_w_d;
  end

  property p_one_busy;
    @(posedge clk_i) disable iff (!rst_ni) oval_q |-> state_q == StIdle;
  endproperty
  a_one_busy: assert property (p_one_busy) else $error("result while busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxRanges)) else $error("range count beyond table");

  a_ov_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && !ok_q) |=> $stable(total_q)) else $error("total moved on refusal");
endmodule

// File: bench/interval_set_range_assign_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_set_range_assign_top_tb
// checks mark and clear requests on the range table against a local model
// of the sorted range list, over several domain sizes and idle patterns
// ----------------------------------------------------------------------------
module interval_set_range_assign_top_tb;
  import isra_pkg::*;

  localparam int unsigned MaxRng = MaxRangesDef;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [FieldBits-1:0] cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 func_i = 1'b0;
  logic [FieldBits-1:0] range_low_i = '0;
  logic [FieldBits-1:0] range_high_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [FieldBits-1:0] marked_total_o;
  logic                 table_overflow_o;

  interval_set_range_assign_top dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .range_low_i, .range_high_i,
    .out_valid_o, .out_stall_i, .marked_total_o, .table_overflow_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [31:0] total;
    logic        ovf;
  } marked_res_t;

  // model of the range table
  logic [63:0] dom_size;
  logic [63:0] rng_lo [MaxRng];
  logic [63:0] rng_hi [MaxRng];
  int unsigned rng_cnt;
  logic [63:0] mark_sum;

  marked_res_t expected_marks [$];
  int          errors = 0;
  int          n_items = 0;
  int          n_ovf = 0;
  int          send_idle = 0;
  int          recv_stall = 0;

  task automatic load_domain(input logic [31:0] d);
    dom_size = {32'd0, d};
    if (d >= 1) begin
      rng_lo[0] = 64'd1;
      rng_hi[0] = dom_size;
      rng_cnt   = 1;
      mark_sum  = dom_size;
    end else begin
      rng_cnt  = 0;
      mark_sum = 0;
    end
  endtask

  function automatic marked_res_t apply_range(input logic fn, input logic [31:0] lo_in,
                                              input logic [31:0] hi_in);
    logic [63:0] lo, hi, ms, me, s, e, sum;
    logic [63:0] ns [MaxRng+2];
    logic [63:0] ne [MaxRng+2];
    int unsigned n;
    bit ok, placed;
    marked_res_t r;
    lo = {32'd0, lo_in};
    hi = {32'd0, hi_in};
    n = 0;
    ok = 1;
    placed = 0;
    if (lo < 1) lo = 1;
    if (hi > dom_size) hi = dom_size;
    r.ovf = 1'b0;
    if (hi >= lo) begin
      if (fn == FuncMark) begin
        ms = lo;
        me = hi;
        for (int i = 0; i < rng_cnt && ok; i++) begin
          s = rng_lo[i];
          e = rng_hi[i];
          if (e + 1 < lo) begin
            ns[n] = s; ne[n] = e; n++;
          end else if (s > hi + 1) begin
            if (!placed) begin
              ns[n] = ms; ne[n] = me; n++;
              placed = 1;
            end
            ns[n] = s; ne[n] = e; n++;
          end else begin
            if (s < ms) ms = s;
            if (e > me) me = e;
          end
        end
        if (!placed) begin
          ns[n] = ms; ne[n] = me; n++;
        end
      end else begin
        for (int i = 0; i < rng_cnt; i++) begin
          s = rng_lo[i];
          e = rng_hi[i];
          if (e < lo || s > hi) begin
            ns[n] = s; ne[n] = e; n++;
          end else begin
            if (s < lo) begin
              ns[n] = s; ne[n] = lo - 1; n++;
            end
            if (e > hi && n <= MaxRng) begin
              ns[n] = hi + 1; ne[n] = e; n++;
            end
          end
          if (n > MaxRng) break;
        end
      end
      if (n > MaxRng) begin
        r.ovf = 1'b1;
      end else begin
        sum = 0;
        for (int i = 0; i < n; i++) begin
          rng_lo[i] = ns[i];
          rng_hi[i] = ne[i];
          sum += ne[i] - ns[i] + 1;
        end
        rng_cnt  = n;
        mark_sum = sum;
      end
    end
    r.total = mark_sum[31:0];
    return r;
  endfunction

  task automatic send_request(input logic fn, input logic [31:0] lo, input logic [31:0] hi);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    expected_marks.insert(expected_marks.size(), apply_range(fn, lo, hi));
    func_i       <= fn;
    range_low_i  <= lo;
    range_high_i <= hi;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_marks.size() != 0) @(posedge clk_i);
    repeat (MaxRng + 10) @(posedge clk_i);
  endtask

  task automatic write_domain(input logic [31:0] d);
    wait_drain();
    cfg_data_i  <= d;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    load_domain(d);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk_i) begin
    marked_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_marks.size() == 0) begin
        $display("%0t: unexpected beat total %0d ovf %0b", $time, marked_total_o,
                 table_overflow_o);
        errors++;
      end else begin
        want = expected_marks.pop_front();
        if (want.ovf) n_ovf++;
        if (marked_total_o !== want.total) begin
          $display("%0t: marked_total expected %0d actual %0d", $time, want.total,
                   marked_total_o);
          errors++;
        end
        if (table_overflow_o !== want.ovf) begin
          $display("%0t: table_overflow expected %0b actual %0b", $time, want.ovf,
                   table_overflow_o);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_pos(input logic [31:0] d);
    case ($urandom_range(9))
      0: return $urandom();
      1: return 0;
      2: return d;
      3: return d + 1;
      default: return (d == 0) ? 0 : $urandom_range(d, 1);
    endcase
  endfunction

  task automatic random_batch(input int cnt, input logic [31:0] d);
    logic [31:0] a, b;
    for (int k = 0; k < cnt; k++) begin
      a = rand_pos(d);
      b = ($urandom_range(9) == 0) ? rand_pos(d) : a + $urandom_range(d > 8 ? d / 8 : 3);
      send_request(1'($urandom_range(1)), a, b);
    end
  endtask

  task automatic test_directed();
    write_domain(32'd100);
    send_request(FuncClear, 32'd10, 32'd20);
    send_request(FuncClear, 32'd30, 32'd40);
    send_request(FuncMark, 32'd21, 32'd29);
    send_request(FuncMark, 32'd10, 32'd10);
    send_request(FuncMark, 32'd50, 32'd40);
    send_request(FuncClear, 32'd0, 32'd0);
    send_request(FuncClear, 32'd101, 32'hffff_ffff);
    send_request(FuncClear, 32'd0, 32'hffff_ffff);
    send_request(FuncMark, 32'd1, 32'd1);
    send_request(FuncMark, 32'd100, 32'd100);
    send_request(FuncMark, 32'd3, 32'd3);
    send_request(FuncMark, 32'd2, 32'd2);
    send_request(FuncMark, 32'd0, 32'hffff_ffff);
    write_domain(32'd0);
    send_request(FuncMark, 32'd0, 32'hffff_ffff);
    send_request(FuncClear, 32'd1, 32'd5);
    write_domain(32'hffff_ffff);
    send_request(FuncClear, 32'h8000_0000, 32'h8000_0000);
    send_request(FuncClear, 32'hffff_ffff, 32'hffff_ffff);
    send_request(FuncMark, 32'hffff_ffff, 32'hffff_ffff);
    send_request(FuncClear, 32'h5555_5555, 32'haaaa_aaaa);
  endtask

  task automatic test_overflow();
    write_domain(32'd400);
    for (int k = 0; k < MaxRng + 2; k++) send_request(FuncClear, 2 + 3 * k, 2 + 3 * k);
    send_request(FuncMark, 32'd2, 32'd2);
    send_request(FuncClear, 32'd390, 32'd390);
  endtask

  task automatic test_random();
    logic [31:0] doms [5] = '{32'd1, 32'd60, 32'd500, 32'd100000, 32'hffff_ffff};
    int idle_s [4] = '{0, 88, 0, 24};
    int idle_r [4] = '{0, 0, 88, 24};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = idle_s[ph];
      recv_stall = idle_r[ph];
      for (int j = 0; j < 5; j++) begin
        write_domain(doms[(j + ph) % 5]);
        random_batch(40, doms[(j + ph) % 5]);
        if (j == 2) wait_drain();
      end
    end
    send_idle  = 0;
    recv_stall = 0;
    write_domain(32'd300);
    random_batch(100, 32'd300);
  endtask

  initial begin
    load_domain(32'd1);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random();
    wait_drain();
    $display("ran %0d requests, %0d refused as table full, over domains 0 to 2^32-1",
             n_items, n_ovf);
    if (errors == 0 && expected_marks.size() == 0) begin
      $display("** interval_set_range_assign_top: PASSED **");
    end else begin
      $display("** interval_set_range_assign_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** interval_set_range_assign_top: FAILED **");
    $finish;
  end
endmodule
